FILE: sv/ktsd_pkg.sv
// Shared types and codes for the keyed table block.
// Beat structs for both channels, command and status codes, default sizes.
`default_nettype none

package ktsd_pkg;

  localparam int KEY_W        = 40;
  localparam int NAME_W       = 16;
  localparam int POS_W        = 7;
  localparam int INDEX_W      = 6;
  localparam int TALLY_W      = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int DIGITS_DEF   = 10;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_COUNT  = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_DEDUP  = 3'd4;
  localparam logic [2:0] CMD_SIZE   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADPOS   = 2'd3;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [KEY_W-1:0]  phone_key;
    logic [NAME_W-1:0] name_handle;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] found_index;
    logic [NAME_W-1:0]  found_name;
    logic [TALLY_W-1:0] tally;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: sv/ktsd_store.sv
// Entry memory: one write port, one read port, read data registered.
// Each word holds a stored key above a name handle. No package use.
`default_nettype none

module ktsd_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/ktsd_ctrl.sv
// Command sequencer: decodes a beat, walks the entry memory and builds one result.
// Uses ktsd_pkg for beat types and codes; drives the ports of ktsd_store.
`default_nettype none

module ktsd_ctrl #(
  parameter int CAPACITY = ktsd_pkg::CAPACITY_DEF,
  parameter int DIGITS   = ktsd_pkg::DIGITS_DEF,
  parameter int MW       = 56
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ktsd_pkg::in_beat_t          in_data_i,
  output logic                             done_valid_o,
  input  wire logic                        done_ready_i,
  output ktsd_pkg::out_beat_t              done_data_o,
  output logic                             wr_en_o,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr_o,
  output logic [MW-1:0]                    wr_data_o,
  output logic                             rd_en_o,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr_o,
  input  wire logic [MW-1:0]               rd_data_i
);
  import ktsd_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SKW = (4 * DIGITS < KEY_W) ? 4 * DIGITS : KEY_W;
  localparam int PW  = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DD_RD  = 3'd3;
  localparam logic [2:0] S_DD_LD  = 3'd4;
  localparam logic [2:0] S_DD_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [SKW-1:0]    key_q, key_d;
  logic [NAME_W-1:0] hname_q, hname_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     kept_q, kept_d;
  logic [CW-1:0]     tally_q, tally_d;
  logic              pend_q;
  logic [AW-1:0]     paddr_q;
  out_beat_t         res_q, res_d;

  logic [SKW-1:0]    rd_key;
  logic [NAME_W-1:0] rd_name;
  logic              hit;
  logic [SKW-1:0]    in_key;

  assign rd_key  = rd_data_i[MW-1:NAME_W];
  assign rd_name = rd_data_i[NAME_W-1:0];
  assign hit     = pend_q && (rd_key == key_q);
  assign in_key  = in_data_i.phone_key[SKW-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    hname_d   = hname_q;
    idx_d     = idx_q;
    i_d       = i_q;
    kept_d    = kept_q;
    tally_d   = tally_q;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[AW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          key_d   = in_key;
          idx_d   = '0;
          tally_d = '0;
          res_d.status      = ST_OK;
          res_d.found_index = '0;
          res_d.found_name  = '0;
          res_d.tally       = TALLY_W'(cnt_q);
          state_d = S_DONE;
          unique case (in_data_i.cmd)
            CMD_APPEND: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en_o     = 1'b1;
                wr_addr_o   = cnt_q[AW-1:0];
                wr_data_o   = {in_key, in_data_i.name_handle};
                cnt_d       = cnt_q + 1'b1;
                res_d.tally = TALLY_W'(cnt_q + 1'b1);
              end
            end
            CMD_FIND: begin
              if (cnt_q == '0) res_d.status = ST_NOTFOUND;
              else state_d = S_SCAN;
            end
            CMD_COUNT: begin
              if (cnt_q != '0) state_d = S_SCAN;
            end
            CMD_DELETE: begin
              if (in_data_i.position == '0 ||
                  PW'(in_data_i.position) > PW'(cnt_q)) begin
                res_d.status = ST_BADPOS;
              end else begin
                // first entry to move down sits right after the deleted one
                idx_d   = CW'(in_data_i.position);
                state_d = S_SHIFT;
              end
            end
            CMD_DEDUP: begin
              i_d    = '0;
              kept_d = '0;
              if (cnt_q != '0) state_d = S_DD_RD;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        rd_en_o = (idx_q < cnt_q);
        if (rd_en_o) idx_d = idx_q + 1'b1;
        tally_d = tally_q + CW'(hit);
        if (cmd_q == CMD_FIND && hit) begin
          res_d.found_index = INDEX_W'(paddr_q);
          res_d.found_name  = rd_name;
          state_d           = S_DONE;
        end else if (pend_q && !rd_en_o) begin
          // last beat of the walk is in
          if (cmd_q == CMD_FIND) res_d.status = ST_NOTFOUND;
          else res_d.tally = TALLY_W'(tally_q + CW'(hit));
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        rd_en_o = (idx_q < cnt_q);
        if (rd_en_o) idx_d = idx_q + 1'b1;
        // write lands two slots below the read issued this cycle
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = paddr_q - 1'b1;
          wr_data_o = rd_data_i;
        end
        if (!rd_en_o) begin
          cnt_d       = cnt_q - 1'b1;
          res_d.tally = TALLY_W'(cnt_q - 1'b1);
          state_d     = S_DONE;
        end
      end

      S_DD_RD: begin
        if (i_q >= cnt_q) begin
          cnt_d       = kept_q;
          res_d.tally = TALLY_W'(kept_q);
          state_d     = S_DONE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = i_q[AW-1:0];
          state_d   = S_DD_LD;
        end
      end

      S_DD_LD: begin
        key_d   = rd_key;
        hname_d = rd_name;
        idx_d   = '0;
        state_d = S_DD_CMP;
      end

      S_DD_CMP: begin
        rd_en_o = (idx_q < kept_q);
        if (rd_en_o) idx_d = idx_q + 1'b1;
        if (hit) begin
          i_d     = i_q + 1'b1;
          state_d = S_DD_RD;
        end else if (!rd_en_o) begin
          // no earlier kept entry has this key: compact it down
          rd_en_o   = 1'b0;
          wr_en_o   = 1'b1;
          wr_addr_o = kept_q[AW-1:0];
          wr_data_o = {key_q, hname_q};
          kept_d    = kept_q + 1'b1;
          i_d       = i_q + 1'b1;
          state_d   = S_DD_RD;
        end
      end

      S_DONE: begin
        if (done_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    hname_q <= hname_d;
    idx_q   <= idx_d;
    i_q     <= i_d;
    kept_q  <= kept_d;
    tally_q <= tally_d;
    res_q   <= res_d;
    paddr_q <= rd_addr_o;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign done_valid_o = (state_q == S_DONE);
  assign done_data_o  = res_q;

endmodule

`default_nettype wire

FILE: sv/keyed_table_search_delete_dedup.sv
// Top level of the keyed table: output register, entry memory and sequencer.
// Depends on ktsd_pkg, ktsd_store and ktsd_ctrl.
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+-----------------------
//   command  | in        | in_valid_i / in_ready_o | ktsd_pkg::in_beat_t
//   result   | out       | out_valid_o/out_ready_i | ktsd_pkg::out_beat_t
//
// One command at a time. Append, size and rejected commands go straight to the
// result. Find and count walk the entries, one memory read per cycle. Delete
// moves the later entries down, a read and a write each cycle. Duplicate removal
// reads each entry, then compares it with the kept entries in turn, one read each,
// until one matches; it is bound by the single read port of the entry memory.
// Reset clears the entry count only; no clearing pass. A result held in the
// output register does not block the next command; it stalls only at its end.
`default_nettype none

module keyed_table_search_delete_dedup #(
  parameter int CAPACITY = ktsd_pkg::CAPACITY_DEF,
  parameter int DIGITS   = ktsd_pkg::DIGITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ktsd_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ktsd_pkg::out_beat_t      out_data_o
);
  import ktsd_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int SKW = (4 * DIGITS < KEY_W) ? 4 * DIGITS : KEY_W;
  localparam int MW  = SKW + NAME_W;

  logic          done_valid, done_ready;
  out_beat_t     done_data;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data, rd_data;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_data_q;

  ktsd_store #(
    .DEPTH (CAPACITY),
    .WIDTH (MW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ktsd_ctrl #(
    .CAPACITY (CAPACITY),
    .DIGITS   (DIGITS),
    .MW       (MW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .done_data_o  (done_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data)
  );

  assign done_ready  = !out_valid_q || out_ready_i;
  assign out_valid_d = (done_valid && done_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_valid && done_ready) begin
      out_data_q <= done_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // one command in flight: the sequencer leaves idle once a beat is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("command taken while another is in flight");

  // schedule keeps reads and writes of the same entry apart
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("read and write to the same entry in one cycle");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (int'(wr_addr) < CAPACITY))
    else $error("entry write beyond capacity");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for keyed_table_search_delete_dedup.
// Directed table then random command streams, checked against an in-bench table model.
// Depends on ktsd_pkg and the keyed_table_search_delete_dedup RTL.
`default_nettype none

module tb_top;
  import ktsd_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int POOL_N      = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 4 * DIGITS_DEF);
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  // Spare command codes, handled like size.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  // Table model state
  logic [KEY_W-1:0]  tbl_key  [CAP];
  logic [NAME_W-1:0] tbl_name [CAP];
  int                tbl_len;

  out_beat_t        pending_results[$];
  row_t             directed_rows[$];
  logic [KEY_W-1:0] key_pool[POOL_N];
  int               err_count;
  int               send_idle_pct;
  int               stall_pct;
  int               hold_reqs;
  int               idle_cycles;

  keyed_table_search_delete_dedup i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic out_beat_t apply_command(in_beat_t b);
    out_beat_t        r;
    logic [KEY_W-1:0] key;
    int               hit;
    int               n;
    int               kept;
    bit               seen;
    r   = '0;
    key = b.phone_key & KEY_MASK;
    case (b.cmd)
      CMD_APPEND: begin
        if (tbl_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[tbl_len]  = key;
          tbl_name[tbl_len] = b.name_handle;
          tbl_len++;
        end
      end
      CMD_FIND: begin
        hit = -1;
        for (int i = 0; i < tbl_len; i++) begin
          if (tbl_key[i] == key) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found_index = INDEX_W'(hit);
          r.found_name  = tbl_name[hit];
        end
      end
      CMD_COUNT: begin
        n = 0;
        for (int i = 0; i < tbl_len; i++)
          if (tbl_key[i] == key) n++;
      end
      CMD_DELETE: begin
        if (b.position == 0 || int'(b.position) > tbl_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int j = int'(b.position) - 1; j + 1 < tbl_len; j++) begin
            tbl_key[j]  = tbl_key[j + 1];
            tbl_name[j] = tbl_name[j + 1];
          end
          tbl_len--;
        end
      end
      CMD_DEDUP: begin
        kept = 0;
        for (int i = 0; i < tbl_len; i++) begin
          seen = 1'b0;
          for (int k = 0; k < kept; k++)
            if (tbl_key[k] == tbl_key[i]) seen = 1'b1;
          if (!seen) begin
            tbl_key[kept]  = tbl_key[i];
            tbl_name[kept] = tbl_name[i];
            kept++;
          end
        end
        tbl_len = kept;
      end
      default: ;
    endcase
    r.tally = (b.cmd == CMD_COUNT) ? TALLY_W'(n) : TALLY_W'(tbl_len);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  function automatic row_t mk_row(logic [2:0] cmd, logic [KEY_W-1:0] key,
                                  logic [NAME_W-1:0] name, logic [POS_W-1:0] pos,
                                  bit typed, logic [1:0] st, logic [INDEX_W-1:0] idx,
                                  logic [NAME_W-1:0] fname, logic [TALLY_W-1:0] tally);
    row_t r;
    r.beat  = '{cmd: cmd, phone_key: key, name_handle: name, position: pos};
    r.typed = typed;
    r.want  = '{status: st, found_index: idx, found_name: fname, tally: tally};
    return r;
  endfunction

  // Biased toward pool keys so finds hit and duplicates pile up; append rate
  // follows the fill level to keep the table moving between empty and full.
  function automatic in_beat_t next_command();
    in_beat_t b;
    int       app;
    int       sub;
    b.phone_key   = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_N - 1)]
                                              : random_key();
    b.name_handle = NAME_W'($urandom);
    b.position    = POS_W'($urandom);
    app = (tbl_len < 8) ? 600 : ((tbl_len > 48) ? 200 : 380);
    if ($urandom_range(999) < app) begin
      b.cmd = CMD_APPEND;
    end else begin
      sub = $urandom_range(99);
      if (sub < 35)      b.cmd = CMD_FIND;
      else if (sub < 60) b.cmd = CMD_COUNT;
      else if (sub < 88) b.cmd = CMD_DELETE;
      else if (sub < 91) b.cmd = CMD_DEDUP;
      else if (sub < 96) b.cmd = CMD_SIZE;
      else if (sub < 98) b.cmd = CMD_SPARE_A;
      else               b.cmd = CMD_SPARE_B;
    end
    if (b.cmd == CMD_DELETE && tbl_len > 0 && $urandom_range(99) < 80)
      b.position = POS_W'($urandom_range(1, tbl_len));
    // occasional junk beat
    if ($urandom_range(99) < 5) b = in_beat_t'({$urandom, $urandom});
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk_i); while (!in_ready);
    pred = apply_command(b);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int n_items);
    int               sent;
    int               fill_n;
    logic [KEY_W-1:0] fill_key;
    in_beat_t         b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(149) == 0) begin
        // fill to capacity and push two appends past it
        fill_key = key_pool[0];
        fill_n   = CAP - tbl_len + 2;
        repeat (fill_n) begin
          b.cmd         = CMD_APPEND;
          b.phone_key   = $urandom_range(1) ? fill_key : key_pool[$urandom_range(POOL_N - 1)];
          b.name_handle = NAME_W'($urandom);
          b.position    = POS_W'($urandom);
          send_beat(b, 1'b0, '0);
        end
        sent += fill_n;
      end else begin
        send_beat(next_command(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off per request.
  initial begin
    int holds_served;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.found_index !== want.found_index)
          report_mismatch("found_index", out_data.found_index, want.found_index);
        if (out_data.found_name !== want.found_name)
          report_mismatch("found_name", out_data.found_name, want.found_name);
        if (out_data.tally !== want.tally)
          report_mismatch("tally", out_data.tally, want.tally);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("keyed_table_search_delete_dedup: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int send_pcts[4];
    int stall_pcts[4];
    in_valid      = 1'b0;
    in_data       = '0;
    rst_ni        = 1'b0;
    tbl_len       = 0;
    err_count     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    send_pcts     = '{0, 57, 0, 12};
    stall_pcts    = '{0, 0, 57, 12};

    // empty table
    directed_rows.push_back(mk_row(CMD_SIZE,   '0, '0, '0, 1, ST_OK,       '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_FIND,   '0, '0, '0, 1, ST_NOTFOUND, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_COUNT,  '0, '0, '0, 1, ST_OK,       '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 1,  1, ST_BADPOS,   '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_DEDUP,  '0, '0, '0, 1, ST_OK,       '0, '0, 0));
    // extremes of key and name, a non-BCD key, a duplicate
    directed_rows.push_back(mk_row(CMD_APPEND, KEY_ONES, 16'hFFFF, '0, 1, ST_OK, '0, '0, 1));
    directed_rows.push_back(mk_row(CMD_APPEND, '0, '0, 7'h7F, 1, ST_OK, '0, '0, 2));
    directed_rows.push_back(mk_row(CMD_APPEND, 40'h12_3456_7890, 16'h1234, '0, 1,
                                   ST_OK, '0, '0, 3));
    directed_rows.push_back(mk_row(CMD_APPEND, KEY_ONES, 16'h0001, '0, 1, ST_OK, '0, '0, 4));
    directed_rows.push_back(mk_row(CMD_APPEND, 40'hAB_CDEF_ABCD, 16'h8000, '0, 1,
                                   ST_OK, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_FIND,  KEY_ONES, '0, '0, 1, ST_OK, '0, 16'hFFFF, 5));
    directed_rows.push_back(mk_row(CMD_COUNT, KEY_ONES, '0, '0, 0, ST_OK, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_FIND, 40'h99_9999_9999, '0, '0, 1,
                                   ST_NOTFOUND, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_FIND, 40'hAB_CDEF_ABCD, '0, '0, 0, ST_OK, '0, '0, 0));
    // bad positions: zero, one past the end, top of the field
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 0,     1, ST_BADPOS, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 6,     1, ST_BADPOS, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 7'h7F, 1, ST_BADPOS, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_SPARE_A, KEY_ONES, 16'hFFFF, 7'h7F, 1,
                                   ST_OK, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_SPARE_B, '0, '0, '0, 1, ST_OK, '0, '0, 5));
    directed_rows.push_back(mk_row(CMD_DEDUP, '0, '0, '0, 0, ST_OK, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_FIND, 40'h12_3456_7890, '0, '0, 0, ST_OK, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 1, 0, ST_OK, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_DELETE, '0, '0, 3, 0, ST_OK, '0, '0, 0));
    directed_rows.push_back(mk_row(CMD_SIZE,   '0, '0, '0, 0, ST_OK, '0, '0, 0));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      stall_pct     = stall_pcts[ph];
      foreach (key_pool[k]) key_pool[k] = random_key();
      if (ph == 2) hold_reqs++;
      run_phase(482);
    end
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("keyed_table_search_delete_dedup: match");
    end else begin
      $display("keyed_table_search_delete_dedup: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
